// ===== hw/rtl/lru_pkg.sv =====
// Shared constants and types for the LRU page replacement block.
`default_nettype none

package lru_pkg;

  // Default frame count and page number width
  localparam int unsigned FRAMES_DEF    = 8;
  localparam int unsigned PAGE_BITS_DEF = 16;

  // Configuration register width and reset value
  localparam int unsigned CFG_W          = 4;
  localparam int unsigned FRAMES_USE_RST = 3;

  // Fixed result field widths
  localparam int unsigned FIDX_W = 3;
  localparam int unsigned FCNT_W = 32;

  // Per-reference status from the frame table to the result register
  typedef struct packed {
    logic              hit;
    logic [FIDX_W-1:0] frame_index;
    logic              evicted_valid;
    logic [FCNT_W-1:0] fault_count;
  } lru_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lru_req_if.sv =====
// Request channel: one page reference per transaction.
`default_nettype none

interface lru_req_if #(
  parameter int unsigned PAGE_BITS = lru_pkg::PAGE_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page;
  logic                 end_of_string;

  modport source (output valid, page, end_of_string, input ready);
  modport sink   (input valid, page, end_of_string, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lru_rsp_if.sv =====
// Response channel: one replacement result per transaction.
`default_nettype none

interface lru_rsp_if #(
  parameter int unsigned PAGE_BITS = lru_pkg::PAGE_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [lru_pkg::FIDX_W-1:0]  frame_index;
  logic                        evicted_valid;
  logic [PAGE_BITS-1:0]        evicted_page;
  logic [lru_pkg::FCNT_W-1:0]  fault_count;

  modport source (output valid, hit, frame_index, evicted_valid, evicted_page, fault_count,
                  input ready);
  modport sink   (input valid, hit, frame_index, evicted_valid, evicted_page, fault_count,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lru_frame_table.sv =====
// Frame table: parallel lookup, LRU victim choice, rank aging and fault counter.
`default_nettype none

module lru_frame_table #(
  parameter int unsigned FRAMES    = lru_pkg::FRAMES_DEF,
  parameter int unsigned PAGE_BITS = lru_pkg::PAGE_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        upd_i,
  input  wire logic [PAGE_BITS-1:0]        page_i,
  input  wire logic                        eos_i,
  input  wire logic [lru_pkg::CFG_W-1:0]   frames_in_use_i,
  output lru_pkg::lru_status_t             status_o,
  output logic      [PAGE_BITS-1:0]        evicted_page_o
);
  import lru_pkg::*;

  localparam int unsigned IDX_W  = $clog2(FRAMES);
  localparam int unsigned RANK_W = IDX_W;

  logic [PAGE_BITS-1:0] page_q [FRAMES];
  logic [FRAMES-1:0]    valid_q, valid_d;
  logic [RANK_W-1:0]    rank_q [FRAMES];
  logic [RANK_W-1:0]    rank_d [FRAMES];
  logic [FCNT_W-1:0]    fault_q, fault_d;

  logic [FRAMES-1:0] in_lim, match, empty, oldest, sel;
  logic              hit, any_empty, fill, evict;
  logic [IDX_W-1:0]  frame;
  logic [RANK_W-1:0] old_rank;

  // Search the frames in use: match, first empty, and oldest resident page
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      in_lim[i] = (i == 0) || (32'(frames_in_use_i) > 32'(i));
      match[i]  = in_lim[i] && valid_q[i] && (page_q[i] == page_i);
      empty[i]  = in_lim[i] && !valid_q[i];
      oldest[i] = in_lim[i];
      for (int j = 0; j < FRAMES; j++) begin
        if (in_lim[j] && (rank_q[j] > rank_q[i])) begin
          oldest[i] = 1'b0;
        end
      end
    end
  end

  assign hit       = |match;
  assign any_empty = |empty;
  assign fill      = !hit && any_empty;
  assign evict     = !hit && !any_empty;
  assign sel       = hit ? match : (any_empty ? empty : oldest);

  // Pick the lowest selected frame
  always_comb begin
    frame = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (sel[i]) begin
        frame = IDX_W'(i);
      end
    end
  end

  assign old_rank = rank_q[frame];

  // Age younger resident frames and make the chosen frame most recent
  always_comb begin
    valid_d        = valid_q;
    valid_d[frame] = 1'b1;
    for (int i = 0; i < FRAMES; i++) begin
      rank_d[i] = rank_q[i];
      if ((IDX_W'(i) != frame) && valid_q[i] && (fill || (rank_q[i] < old_rank))) begin
        rank_d[i] = rank_q[i] + 1'b1;
      end
    end
    rank_d[frame] = '0;
  end

  // Count faults, holding at all ones
  always_comb begin
    fault_d = fault_q;
    if (!hit && (fault_q != {FCNT_W{1'b1}})) begin
      fault_d = fault_q + 1'b1;
    end
  end

  assign status_o.hit           = hit;
  assign status_o.frame_index   = FIDX_W'(frame);
  assign status_o.evicted_valid = evict;
  assign status_o.fault_count   = fault_d;
  assign evicted_page_o         = evict ? page_q[frame] : '0;

  // Commit control state; clear it at the end of a string
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      fault_q <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (upd_i) begin
      if (eos_i) begin
        valid_q <= '0;
        fault_q <= '0;
        for (int i = 0; i < FRAMES; i++) begin
          rank_q[i] <= '0;
        end
      end else begin
        valid_q <= valid_d;
        fault_q <= fault_d;
        for (int i = 0; i < FRAMES; i++) begin
          rank_q[i] <= rank_d[i];
        end
      end
    end
  end

  // Write the page into the chosen frame on a fault
  always_ff @(posedge clk_i) begin
    if (upd_i && !hit) begin
      page_q[frame] <= page_i;
    end
  end

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i && hit |-> !evict)
    else $error("hit reported together with an eviction");

  a_eos_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i && eos_i |=> (valid_q == '0) && (fault_q == '0))
    else $error("end of string did not clear the frames");

  a_fill_by_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i && !eos_i |=> $countones(valid_q) <= $past($countones(valid_q)) + 1)
    else $error("more than one frame filled by one reference");

  a_fault_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i && !eos_i |=> fault_q >= $past(fault_q))
    else $error("fault count went backwards within a string");

endmodule

`default_nettype wire

// ===== hw/rtl/lru_page_replacement.sv =====
// Top level of the LRU page replacement block.
// Takes one page reference per cycle while results are taken, and answers each with hit or
// fault, the frame used, any evicted page and the running fault count. A reference is held
// in the input register; from there the frame search, victim choice and rank update run
// combinationally into the result register, which is loaded once it is free or being
// drained. The sustained rate is one reference per clock while rsp.ready stays high, as the
// lookup over all frames is combinational. A stalled result holds the input register,
// so at most two references are in flight. The frame count register may be changed only
// while no reference is in flight.
// Values of 0 act as 1 and values above FRAMES act as FRAMES. A reference flagged as end
// of string is answered normally and then empties the frames and clears the fault count.
`default_nettype none

module lru_page_replacement #(
  parameter int unsigned FRAMES    = lru_pkg::FRAMES_DEF,
  parameter int unsigned PAGE_BITS = lru_pkg::PAGE_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [lru_pkg::CFG_W-1:0] cfg_wdata_i,
  lru_req_if.sink                        req,
  lru_rsp_if.source                      rsp
);
  import lru_pkg::*;

  logic [CFG_W-1:0]     cfg_q;
  logic                 in_valid_q;
  logic [PAGE_BITS-1:0] in_page_q;
  logic                 in_eos_q;
  logic                 out_valid_q;
  lru_status_t          out_status_q;
  logic [PAGE_BITS-1:0] out_evpage_q;

  logic                 advance;
  lru_status_t          status;
  logic [PAGE_BITS-1:0] evicted_page;

  // Move a reference into the result register when it is free or being drained
  assign advance   = in_valid_q && (!out_valid_q || rsp.ready);
  assign req.ready = !in_valid_q || advance;

  // Hold the frame count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_W'(FRAMES_USE_RST);
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // Input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req.valid && req.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      in_page_q <= req.page;
      in_eos_q  <= req.end_of_string;
    end
  end

  lru_frame_table #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_table (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .upd_i           (advance),
    .page_i          (in_page_q),
    .eos_i           (in_eos_q),
    .frames_in_use_i (cfg_q),
    .status_o        (status),
    .evicted_page_o  (evicted_page)
  );

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_status_q <= status;
      out_evpage_q <= evicted_page;
    end
  end

  assign rsp.valid         = out_valid_q;
  assign rsp.hit           = out_status_q.hit;
  assign rsp.frame_index   = out_status_q.frame_index;
  assign rsp.evicted_valid = out_status_q.evicted_valid;
  assign rsp.evicted_page  = out_evpage_q;
  assign rsp.fault_count   = out_status_q.fault_count;

endmodule

`default_nettype wire
